// ===== src/assert_macros.svh =====
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/fpmt_pkg.sv =====
package fpmt_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 64;

	localparam logic [63:0] DBL_POS_INF  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] DBL_REL_DFLT = 64'h3F50_624D_D2F1_A9FC; // 0.001

	typedef enum logic [0:0] {
		REG_REL = 1'b0,
		REG_ABS = 1'b1
	} reg_idx_t;

	// operands of rel * |v|: value = m * 2^x
	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic        [52:0] ma;
		logic        [52:0] mb;
		logic signed [12:0] x;
	} mul_op_t;

	function automatic logic dbl_lt(logic [63:0] a, logic [63:0] b);
		logic a_nan;
		logic b_nan;
		logic r;
		a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
		b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		if (a_nan || b_nan) begin
			r = 1'b0;
		end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
			r = 1'b0;
		end else if (a[63] != b[63]) begin
			r = a[63];
		end else if (!a[63]) begin
			r = a[62:0] < b[62:0];
		end else begin
			r = a[62:0] > b[62:0];
		end
		return r;
	endfunction

endpackage

// ===== src/fp_mantissa_truncate_unit.sv =====
// Pipeline: input register, split multiply, bound select, erase count and round, in that order.
// Throughput: one value per cycle while the output is not stalled; the split 53x53 multiply and the
// round-and-pack steps each take their own register stage.
// Reset: all stage valid bits clear; both bounds return to +infinity.
module fp_mantissa_truncate_unit #(
	parameter int unsigned VALUE_WIDTH = fpmt_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [63:0] value_bits,
	input  logic        block_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] truncated_bits,
	output logic [5:0]  erased_count,
	output logic        block_end_out,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [63:0] wr_data
);

	localparam bit                 SINGLE   = (VALUE_WIDTH == 32);
	localparam logic [5:0]         MANT_W   = SINGLE ? 6'd23 : 6'd52;
	localparam logic [10:0]        EXP_ONES = SINGLE ? 11'h0FF : 11'h7FF;
	localparam logic signed [12:0] BIAS     = SINGLE ? 13'sd127 : 13'sd1023;
	localparam logic signed [12:0] MB_OFS   = SINGLE ? 13'sd150 : 13'sd1075;
	localparam logic [63:0]        WORD_MASK = SINGLE ? 64'h0000_0000_FFFF_FFFF : '1;

	typedef struct packed {
		logic [63:0] v;
		logic        be;
		logic        skip;
	} side_t;

	logic [63:0] rel_q, abs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= fpmt_pkg::DBL_POS_INF;
			abs_q <= fpmt_pkg::DBL_POS_INF;
		end else if (wr_en) begin
			unique case (fpmt_pkg::reg_idx_t'(wr_index))
				fpmt_pkg::REG_REL: rel_q <= wr_data;
				fpmt_pkg::REG_ABS: abs_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic [9:1] vld_q;
	logic [9:1] rdy;

	always_comb begin
		rdy[9] = !vld_q[9] || !result_stall;
		for (int k = 8; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= item_valid;
			end
			for (int k = 2; k <= 9; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	assign item_stall = !rdy[1];

	// stage 1: input register
	logic [63:0] v_s1;
	logic        be_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			v_s1  <= value_bits & WORD_MASK;
			be_s1 <= block_end;
		end
	end

	// operand decode
	logic [10:0]         raw_s1, ea, eb1, ea1;
	logic                rel_inf, abs_inf;
	logic [63:0]         rel_eff;
	fpmt_pkg::mul_op_t   op;
	side_t               side_s1;

	always_comb begin
		raw_s1  = SINGLE ? {3'd0, v_s1[30:23]} : v_s1[62:52];
		rel_inf = (rel_q[62:0] == fpmt_pkg::DBL_POS_INF[62:0]);
		abs_inf = (abs_q[62:0] == fpmt_pkg::DBL_POS_INF[62:0]);
		rel_eff = (rel_inf && abs_inf) ? fpmt_pkg::DBL_REL_DFLT : rel_q;
		ea      = rel_eff[62:52];
		ea1     = (ea == 11'd0) ? 11'd1 : ea;
		eb1     = (raw_s1 == 11'd0) ? 11'd1 : raw_s1;
		op.sign = rel_eff[63];
		op.nan  = (ea == 11'h7FF) && (rel_eff[51:0] != 52'd0);
		op.inf  = (ea == 11'h7FF) && (rel_eff[51:0] == 52'd0);
		op.ma   = {ea != 11'd0, rel_eff[51:0]};
		op.mb   = SINGLE ? {29'd0, raw_s1 != 11'd0, v_s1[22:0]}
		                 : {raw_s1 != 11'd0, v_s1[51:0]};
		op.x    = ($signed({2'd0, ea1}) - 13'sd1075) + ($signed({2'd0, eb1}) - MB_OFS);
		side_s1.v    = v_s1;
		side_s1.be   = be_s1;
		side_s1.skip = (raw_s1 == EXP_ONES) || ((v_s1 & (WORD_MASK >> 1)) == 64'd0);
	end

	logic [63:0] dyn_s6;

	fpmt_dyn_mul u_mul (
		.clk (clk),
		.en  (rdy[6:2]),
		.op  (op),
		.dyn (dyn_s6)
	);

	side_t side_s2, side_s3, side_s4, side_s5, side_s6;

	always_ff @(posedge clk) begin
		if (rdy[2]) side_s2 <= side_s1;
		if (rdy[3]) side_s3 <= side_s2;
		if (rdy[4]) side_s4 <= side_s3;
		if (rdy[5]) side_s5 <= side_s4;
		if (rdy[6]) side_s6 <= side_s5;
	end

	// stage 7: error bound = min(abs, rel*|v|)
	logic [63:0] me_s7;
	side_t       side_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			me_s7   <= fpmt_pkg::dbl_lt(dyn_s6, abs_q) ? dyn_s6 : abs_q;
			side_s7 <= side_s6;
		end
	end

	// stage 8: erase count from exponent of bound / ulp
	logic [5:0]          fmsb;
	logic signed [12:0]  lg2, lgq;
	logic [10:0]         raw_s7;
	logic [5:0]          n_n, n_s8;
	side_t               side_s8;

	always_comb begin
		fmsb = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (me_s7[i]) begin
				fmsb = 6'(i);
			end
		end
		raw_s7 = SINGLE ? {3'd0, side_s7.v[30:23]} : side_s7.v[62:52];
		lg2 = (me_s7[62:52] != 11'd0) ? ($signed({2'd0, me_s7[62:52]}) - 13'sd1023)
		                              : ($signed({7'd0, fmsb}) - 13'sd1074);
		lgq = lg2 - ($signed({2'd0, raw_s7}) - BIAS - $signed({7'd0, MANT_W}));
		priority if (me_s7[62:52] == 11'h7FF || (!SINGLE && raw_s7 == 11'd0)) begin
			n_n = MANT_W;
		end else if (me_s7[63] || me_s7[62:0] == 63'd0 || lgq < 13'sd1) begin
			n_n = 6'd0;
		end else if (lgq > $signed({7'd0, MANT_W})) begin
			n_n = MANT_W;
		end else begin
			n_n = lgq[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			n_s8    <= n_n;
			side_s8 <= side_s7;
		end
	end

	// stage 9: round to nearest at bit n, carry may reach exponent
	logic [63:0] kept, res_n, res_s9;
	logic [5:0]  cnt_n, cnt_s9;
	logic        be_s9;
	logic [10:0] kexp;

	always_comb begin
		kept = side_s8.v & ~((64'd1 << n_s8) - 64'd1);
		if (n_s8 != 6'd0 && side_s8.v[n_s8 - 6'd1]) begin
			kept = kept + (64'd1 << n_s8);
		end
		kexp = SINGLE ? {3'd0, kept[30:23]} : kept[62:52];
		if (side_s8.skip || n_s8 == 6'd0 || kexp == EXP_ONES) begin
			res_n = side_s8.v;
			cnt_n = 6'd0;
		end else begin
			res_n = kept & WORD_MASK;
			cnt_n = n_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			res_s9 <= res_n;
			cnt_s9 <= cnt_n;
			be_s9  <= side_s8.be;
		end
	end

	assign result_valid   = vld_q[9];
	assign truncated_bits = res_s9;
	assign erased_count   = cnt_s9;
	assign block_end_out  = be_s9;

endmodule

// ===== src/fpmt_dyn_mul.sv =====
// rel * |v| in double, rounded to nearest even; five register stages
module fpmt_dyn_mul (
	input  logic                 clk,
	input  logic [4:0]           en,
	input  fpmt_pkg::mul_op_t    op,
	output logic [63:0]          dyn
);

	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic signed [12:0] x;
	} side_t;

	side_t side_s2, side_s3, side_s4, side_s5;

	logic [53:0]  pp0_s2;
	logic [52:0]  pp1_s2, pp2_s2;
	logic [51:0]  pp3_s2;
	logic [105:0] p_s3, p_s4;
	logic signed [12:0] sh_s4;
	logic         zero_s4, zero_s5;
	logic [53:0]  m_s5;
	logic         rb_s5, st_s5;
	logic signed [12:0] es_s5;
	logic [63:0]  dyn_s6;

	// stage 2: partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp0_s2  <= op.ma[26:0]  * op.mb[26:0];
			pp1_s2  <= op.ma[26:0]  * op.mb[52:27];
			pp2_s2  <= op.ma[52:27] * op.mb[26:0];
			pp3_s2  <= op.ma[52:27] * op.mb[52:27];
			side_s2 <= '{sign: op.sign, nan: op.nan, inf: op.inf, x: op.x};
		end
	end

	// stage 3: sum
	logic [53:0] mid;
	assign mid = 54'(pp1_s2) + 54'(pp2_s2);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s3    <= 106'(pp0_s2) + (106'(mid) << 27) + (106'(pp3_s2) << 54);
			side_s3 <= side_s2;
		end
	end

	// stage 4: leading one and alignment shift
	logic [6:0]         msb;
	logic signed [12:0] sa, sb;

	always_comb begin
		msb = 7'd0;
		for (int i = 0; i < 106; i++) begin
			if (p_s3[i]) begin
				msb = 7'(i);
			end
		end
		sa = $signed({6'd0, msb}) - 13'sd52;
		sb = -13'sd1074 - side_s3.x;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_s4    <= p_s3;
			sh_s4   <= (sa > sb) ? sa : sb;
			zero_s4 <= (p_s3 == 106'd0);
			side_s4 <= side_s3;
		end
	end

	// stage 5: shift to 53 bits, guard and sticky
	logic [127:0] pe, rem;
	logic [6:0]   rsh, lsh;
	logic [12:0]  neg_sh;
	logic [53:0]  m_n;
	logic         rb_n, st_n;

	always_comb begin
		pe     = {22'd0, p_s4};
		neg_sh = 13'(-sh_s4);
		lsh    = neg_sh[6:0];
		rsh    = (sh_s4 > 13'sd127) ? 7'd127 : sh_s4[6:0];
		rem    = pe & ~({128{1'b1}} << rsh);
		if (sh_s4 > 13'sd0) begin
			m_n  = 54'(pe >> rsh);
			rb_n = rem[rsh - 7'd1];
			st_n = |(rem & ~({128{1'b1}} << (rsh - 7'd1)));
		end else begin
			m_n  = 54'(pe << lsh);
			rb_n = 1'b0;
			st_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_s5    <= m_n;
			rb_s5   <= rb_n;
			st_s5   <= st_n;
			es_s5   <= side_s4.x + sh_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: round and pack
	logic [53:0]        mu, mn;
	logic signed [12:0] e2, eu;
	logic [63:0]        dyn_n;

	always_comb begin
		mu = m_s5 + 54'(rb_s5 && (st_s5 || m_s5[0]));
		if (mu[53]) begin
			mn = mu >> 1;
			e2 = es_s5 + 13'sd1;
		end else begin
			mn = mu;
			e2 = es_s5;
		end
		eu = e2 + 13'sd52;
		if (side_s5.nan) begin
			dyn_n = fpmt_pkg::DBL_QNAN;
		end else if (side_s5.inf) begin
			dyn_n = {side_s5.sign, fpmt_pkg::DBL_POS_INF[62:0]};
		end else if (zero_s5) begin
			dyn_n = {side_s5.sign, 63'd0};
		end else if (mn[52]) begin
			if (eu > 13'sd1023) begin
				dyn_n = {side_s5.sign, fpmt_pkg::DBL_POS_INF[62:0]};
			end else begin
				dyn_n = {side_s5.sign, 11'(eu + 13'sd1023), mn[51:0]};
			end
		end else begin
			dyn_n = {side_s5.sign, 11'd0, mn[51:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dyn_s6 <= dyn_n;
		end
	end

	assign dyn = dyn_s6;

endmodule

// ===== src/fpmt_checker.sv =====
`include "assert_macros.svh"

module fpmt_checker #(
	parameter int unsigned VALUE_WIDTH = fpmt_pkg::VALUE_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [63:0] truncated_bits,
	input logic [5:0]  erased_count,
	input logic        block_end_out
);

	localparam bit         SINGLE = (VALUE_WIDTH == 32);
	localparam logic [5:0] MANT_W = SINGLE ? 6'd23 : 6'd52;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(truncated_bits) && $stable(erased_count) && $stable(block_end_out))
	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, result_valid, erased_count <= MANT_W)
	`ASSERT_IMPLIES(a_low_clear, clk, arst_n, result_valid, (truncated_bits & ((64'd1 << erased_count) - 64'd1)) == 64'd0)
	`ASSERT_IMPLIES(a_single_hi, clk, arst_n, result_valid && SINGLE, truncated_bits[63:32] == 32'd0)

endmodule

bind fp_mantissa_truncate_unit fpmt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_fpmt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.truncated_bits (truncated_bits),
	.erased_count   (erased_count),
	.block_end_out  (block_end_out)
);

// ===== tb/fp_mantissa_truncate_unit_tb.sv =====
`timescale 1ns / 1ps

module fp_mantissa_truncate_unit_tb;

	typedef struct {
		logic [63:0] bits;
		logic [5:0]  count;
		logic        blk_end;
	} trunc_res_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [63:0] value_bits;
	logic        block_end;
	logic        result_valid;
	logic        result_stall;
	logic [63:0] truncated_bits;
	logic [5:0]  erased_count;
	logic        block_end_out;
	logic        wr_en;
	logic [0:0]  wr_index;
	logic [63:0] wr_data;

	logic [63:0] rel_bound;
	logic [63:0] abs_bound;
	trunc_res_t  pending_q[$];
	int          mismatches;
	bit          idle_en;

	logic        took;
	trunc_res_t  seen;

	fp_mantissa_truncate_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.value_bits    (value_bits),
		.block_end     (block_end),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.truncated_bits(truncated_bits),
		.erased_count  (erased_count),
		.block_end_out (block_end_out),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_inf_bits(logic [63:0] b);
		return b[62:0] == fpmt_pkg::DBL_POS_INF[62:0];
	endfunction

	function automatic bit is_finite(real r);
		logic [63:0] b;
		b = $realtobits(r);
		return b[62:52] != 11'h7FF;
	endfunction

	function automatic real exact_pow2(int e);
		logic [63:0] b;
		if (e >= -1022) begin
			b = {1'b0, 11'(e + 1023), 52'd0};
			return $bitstoreal(b);
		end
		if (e >= -1074) begin
			b = 64'd1 << (e + 1074);
			return $bitstoreal(b);
		end
		return 0.0;
	endfunction

	function automatic trunc_res_t predict_trunc(logic [63:0] v, logic be);
		trunc_res_t  res;
		real         rel;
		real         ab;
		real         err;
		real         dyn;
		real         ulp;
		real         q;
		logic [63:0] qb;
		logic [63:0] kept;
		int          lg;
		int unsigned n;
		res.bits = v;
		res.count = 6'd0;
		res.blk_end = be;
		n = 0;
		if (v[62:52] != 11'h7FF && v[62:0] != 63'd0) begin
			rel = $bitstoreal(rel_bound);
			ab = $bitstoreal(abs_bound);
			if (is_inf_bits(rel_bound) && is_inf_bits(abs_bound))
				rel = $bitstoreal(fpmt_pkg::DBL_REL_DFLT);
			err = ab;
			dyn = rel * $bitstoreal({1'b0, v[62:0]});
			if (dyn < err)
				err = dyn;
			ulp = exact_pow2(int'(v[62:52]) - 1075);
			if (!is_finite(err) || ulp == 0.0) begin
				n = 52;
			end else begin
				q = err / ulp;
				qb = $realtobits(q);
				if (qb[62:52] == 11'h7FF) begin
					n = 52;
				end else if (q >= 2.0) begin
					lg = int'(qb[62:52]) - 1023;
					n = (lg > 52) ? 52 : unsigned'(lg);
				end
			end
			if (n != 0) begin
				kept = v & ~((64'd1 << n) - 64'd1);
				if (v[n-1]) begin
					kept = kept + (64'd1 << n);
					if (kept[62:52] == 11'h7FF) begin
						kept = v;
						n = 0;
					end
				end
				res.bits = kept;
			end
		end
		res.count = 6'(n);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatches++;
	endtask

	task automatic send_value(logic [63:0] v, logic be);
		bit acc;
		while (idle_en && $urandom_range(99) < 18) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		value_bits <= v;
		block_end <= be;
		pending_q.push_back(predict_trunc(v, be));
		do begin
			@(negedge clk);
			acc = !item_stall;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_bound(fpmt_pkg::reg_idx_t idx, logic [63:0] d);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == fpmt_pkg::REG_REL)
			rel_bound = d;
		else
			abs_bound = d;
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int unsigned sel;
		v = {$urandom, $urandom};
		sel = $urandom_range(99);
		if (sel < 50)
			v[62:52] = 11'($urandom_range(1150, 900));
		else if (sel < 58)
			v[62:52] = 11'($urandom_range(1, 0));
		else if (sel < 64)
			v[62:52] = 11'($urandom_range(2046, 2040));
		return v;
	endfunction

	task automatic test_specials();
		logic [63:0] vals[$];
		vals = '{64'h0, 64'h8000_0000_0000_0000, fpmt_pkg::DBL_POS_INF,
			64'hFFF0_0000_0000_0000,
			fpmt_pkg::DBL_QNAN, 64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
			64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0800,
			64'h3FFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
			64'h4059_0000_0000_0000, 64'h3FF8_0000_0000_0000};
		foreach (vals[i])
			send_value(vals[i], i[0]);
	endtask

	task automatic test_bound_settings();
		logic [63:0] rels[$];
		logic [63:0] abss[$];
		rels = '{fpmt_pkg::DBL_POS_INF, 64'h3EB0_C6F7_A0B5_ED8D, fpmt_pkg::DBL_POS_INF,
			64'h0, 64'hBF50_624D_D2F1_A9FC, fpmt_pkg::DBL_QNAN, 64'hFFF0_0000_0000_0000,
			64'h3FE0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001};
		abss = '{64'h3F1A_36E2_EB1C_432D, fpmt_pkg::DBL_POS_INF, fpmt_pkg::DBL_POS_INF,
			64'h0, fpmt_pkg::DBL_POS_INF, 64'h3FB9_9999_9999_999A,
			64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, fpmt_pkg::DBL_QNAN,
			64'h0000_0000_0000_0001};
		foreach (rels[i]) begin
			write_bound(fpmt_pkg::REG_REL, rels[i]);
			write_bound(fpmt_pkg::REG_ABS, abss[i]);
			repeat (6)
				send_value(rand_value(), 1'($urandom_range(1)));
			send_value(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
			send_value(64'h0000_0000_0000_0003, 1'b1);
		end
	endtask

	task automatic test_random_stream();
		for (int k = 0; k < 8; k++) begin
			write_bound(fpmt_pkg::REG_REL, $urandom_range(3) == 0 ? fpmt_pkg::DBL_POS_INF :
				{2'b00, 11'($urandom_range(1020, 960)), 51'({$urandom, $urandom})});
			write_bound(fpmt_pkg::REG_ABS, $urandom_range(3) == 0 ? fpmt_pkg::DBL_POS_INF :
				{1'b0, 11'($urandom_range(1100, 900)), 52'({$urandom, $urandom})});
			repeat (50)
				send_value(rand_value(), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_no_idle();
		idle_en = 0;
		write_bound(fpmt_pkg::REG_REL, 64'h3F1A_36E2_EB1C_432D);
		write_bound(fpmt_pkg::REG_ABS, fpmt_pkg::DBL_POS_INF);
		repeat (120)
			send_value(rand_value(), 1'($urandom_range(1)));
		idle_en = 1;
	endtask

	always @(negedge clk) begin
		took <= arst_n && result_valid && !result_stall;
		seen.bits <= truncated_bits;
		seen.count <= erased_count;
		seen.blk_end <= block_end_out;
	end

	always @(posedge clk) begin
		trunc_res_t want;
		if (arst_n) begin
			if (took) begin
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected transfer", seen.bits, 64'h0);
				end else begin
					want = pending_q.pop_front();
					if (seen.bits !== want.bits)
						report_mismatch("truncated_bits", seen.bits, want.bits);
					if (seen.count !== want.count)
						report_mismatch("erased_count", 64'(seen.count), 64'(want.count));
					if (seen.blk_end !== want.blk_end)
						report_mismatch("block_end_out", 64'(seen.blk_end),
							64'(want.blk_end));
				end
			end
			result_stall <= idle_en && ($urandom_range(99) < 18);
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		item_valid = 0;
		value_bits = 0;
		block_end = 0;
		result_stall = 0;
		wr_en = 0;
		wr_index = 0;
		wr_data = 0;
		took = 0;
		mismatches = 0;
		idle_en = 1;
		rel_bound = fpmt_pkg::DBL_POS_INF;
		abs_bound = fpmt_pkg::DBL_POS_INF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_specials();
		test_bound_settings();
		test_random_stream();
		test_no_idle();
		drain();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule
